// ----- sv/hpa_pkg.sv -----
// ============================================================================
// hpa_pkg
// Shared constants, codes and control structures of the handle pool allocator.
// ============================================================================
package hpa_pkg;

  // Pool geometry. Handles travel in HANDLE_W bits and the pool holds one
  // handle for each code of that width.
  localparam int POOL_SIZE = 256;
  localparam int HANDLE_W  = 8;
  localparam int PTR_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = PTR_W + 1;

  // Request opcodes.
  localparam logic [1:0] OP_ALLOC     = 2'd0;
  localparam logic [1:0] OP_TRY_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE      = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREED  = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // Commands to the free list.
  typedef struct packed {
    logic                push;
    logic                pop;
    logic [PTR_W-1:0]    wdata;
  } fifo_ctl_t;

  // Status of the free list.
  typedef struct packed {
    logic                empty;
    logic [PTR_W-1:0]    head_data;
  } fifo_stat_t;

  // One write into the allocated bitmap.
  typedef struct packed {
    logic                wr;
    logic                val;
    logic [PTR_W-1:0]    idx;
  } map_ctl_t;

endpackage

// ----- sv/hpa_if.sv -----
// ============================================================================
// hpa_req_if / hpa_rsp_if
// Valid/ready channels that carry requests into and results out of the pool.
// ============================================================================
interface hpa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] handle_in;

  modport source (output valid, output opcode, output handle_in, input ready);
  modport sink   (input valid, input opcode, input handle_in, output ready);
endinterface

interface hpa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] handle_out;
  logic [1:0] status;

  modport source (output valid, output handle_out, output status, input ready);
  modport sink   (input valid, input handle_out, input status, output ready);
endinterface

// ----- sv/hpa_free_fifo.sv -----
// ============================================================================
// hpa_free_fifo
// Circular free list of returned handles with a registered head word.
// ============================================================================
module hpa_free_fifo (
  input  logic               clk,
  input  logic               rst,
  input  hpa_pkg::fifo_ctl_t ctl,
  output hpa_pkg::fifo_stat_t stat
);
  import hpa_pkg::*;

  logic [PTR_W-1:0] mem [POOL_SIZE];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] head_data;
  logic             do_push;
  logic             do_pop;

  // A push into a full list is dropped; a pop of an empty list is ignored.
  assign do_push    = ctl.push && (count < CNT_W'(POOL_SIZE));
  assign do_pop     = ctl.pop && (count != '0);
  assign head_next  = head + PTR_W'(do_pop);
  assign count_next = count + CNT_W'(do_push) - CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (do_push) begin
        tail <= tail + PTR_W'(1);
      end
    end
  end

  // The read port always looks at the next head, so the oldest entry is
  // ready in a register; a write to that same slot is forwarded.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= ctl.wdata;
    end
    if (do_push && (tail == head_next)) begin
      head_data <= ctl.wdata;
    end else begin
      head_data <= mem[head_next];
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.head_data = head_data;

endmodule

// ----- sv/hpa_alloc_map.sv -----
// ============================================================================
// hpa_alloc_map
// One bit per handle that marks it as handed out; cleared by a pass after reset.
// ============================================================================
module hpa_alloc_map (
  input  logic                        clk,
  input  logic                        rst,
  input  hpa_pkg::map_ctl_t           ctl,
  input  logic                        rd_en,
  input  logic [hpa_pkg::PTR_W-1:0]   rd_idx,
  output logic                        rd_bit,
  output logic                        busy
);
  import hpa_pkg::*;

  logic             mem [POOL_SIZE];
  logic             clearing;
  logic [PTR_W-1:0] clr_idx;

  // After reset every entry is written to zero, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + PTR_W'(1);
      if (clr_idx == PTR_W'(POOL_SIZE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Read data is registered; a write to the slot being read in the same
  // cycle is forwarded so the reader sees the updated bit.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= 1'b0;
    end else if (ctl.wr) begin
      mem[ctl.idx] <= ctl.val;
    end
    if (rd_en) begin
      if (ctl.wr && (ctl.idx == rd_idx)) begin
        rd_bit <= ctl.val;
      end else begin
        rd_bit <= mem[rd_idx];
      end
    end
  end

  assign busy = clearing;

endmodule

// ----- sv/handle_pool_allocator_core.sv -----
// ============================================================================
// handle_pool_allocator_core
// Handle pool with a FIFO free list, a fresh-handle counter and an allocated
// bitmap. Each request yields exactly one result word.
// ============================================================================
// A request's result is loaded into the output register once that is free.
// Throughput: one request per cycle while results are taken; the bitmap takes
// a read and at most one write per request, the free list at most one push or
// pop, and both deliver their read data from registers.
// Reset (rst, synchronous): empties both registers, the free list and the fresh
// counter, then clears the bitmap while requests are held off.
module handle_pool_allocator_core (
  input  logic      clk,
  input  logic      rst,
  hpa_req_if.sink   req,
  hpa_rsp_if.source rsp
);
  import hpa_pkg::*;

  // Input register: holds the request being decoded.
  logic                in_v;
  logic [1:0]          in_op;
  logic [HANDLE_W-1:0] in_h;

  // Output register: holds the result until the consumer takes it.
  logic                out_v;
  logic [HANDLE_W-1:0] out_h;
  logic [1:0]          out_st;

  // Counter of handles never handed out yet.
  logic [CNT_W-1:0]    fresh_cnt;
  logic [CNT_W-1:0]    fresh_cnt_next;

  logic                adv;
  logic                map_bit;
  logic                map_busy;
  fifo_ctl_t           fifo_ctl;
  fifo_stat_t          fifo_stat;
  map_ctl_t            map_ctl;
  logic [HANDLE_W-1:0] res_h;
  logic [1:0]          res_st;

  // The decoded request moves into the output register when that register is
  // empty or is being emptied in the same cycle. All state changes are tied
  // to this move, so each request acts on the pool exactly once. No request
  // is taken while the bitmap is still being cleared after reset.
  assign adv       = in_v && (!out_v || rsp.ready);
  assign req.ready = !map_busy && (!in_v || adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (req.ready) begin
      in_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op <= req.opcode;
      in_h  <= req.handle_in;
    end
  end

  hpa_free_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctl  (fifo_ctl),
    .stat (fifo_stat)
  );

  // Handles are HANDLE_W bits wide and the pool covers every code, so a
  // handle beyond the pool cannot arrive; the bitmap lookup is the whole check.
  // The lookup is made as the request is accepted, so its bit sits in a
  // register beside the input register.
  hpa_alloc_map u_map (
    .clk    (clk),
    .rst    (rst),
    .ctl    (map_ctl),
    .rd_en  (req.valid && req.ready),
    .rd_idx (req.handle_in),
    .rd_bit (map_bit),
    .busy   (map_busy)
  );

  // Request decode. Allocation prefers the oldest freed handle, then a fresh
  // one; a free is accepted only for a handle that is currently out.
  always_comb begin
    fifo_ctl       = '0;
    map_ctl        = '0;
    fresh_cnt_next = fresh_cnt;
    res_h          = '0;
    res_st         = ST_OK;
    case (in_op)
      OP_ALLOC, OP_TRY_ALLOC: begin
        if (!fifo_stat.empty) begin
          fifo_ctl.pop = adv;
          map_ctl.wr   = adv;
          map_ctl.val  = 1'b1;
          map_ctl.idx  = fifo_stat.head_data;
          res_h        = fifo_stat.head_data;
        end else if (in_op == OP_TRY_ALLOC) begin
          res_st = ST_NO_FREED;
        end else if (fresh_cnt < CNT_W'(POOL_SIZE)) begin
          map_ctl.wr  = adv;
          map_ctl.val = 1'b1;
          map_ctl.idx = fresh_cnt[PTR_W-1:0];
          res_h       = fresh_cnt[HANDLE_W-1:0];
          if (adv) begin
            fresh_cnt_next = fresh_cnt + CNT_W'(1);
          end
        end else begin
          res_st = ST_EXHAUSTED;
        end
      end
      OP_FREE: begin
        if (!map_bit) begin
          res_st = ST_NOT_ALLOC;
        end else begin
          map_ctl.wr     = adv;
          map_ctl.val    = 1'b0;
          map_ctl.idx    = in_h;
          fifo_ctl.push  = adv;
          fifo_ctl.wdata = in_h;
        end
      end
      default: begin
        // The unused opcode leaves the pool alone and answers a plain OK.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_cnt <= '0;
      out_v     <= 1'b0;
    end else begin
      fresh_cnt <= fresh_cnt_next;
      if (adv) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_h  <= res_h;
      out_st <= res_st;
    end
  end

  assign rsp.valid      = out_v;
  assign rsp.handle_out = out_h;
  assign rsp.status     = out_st;

endmodule

// ----- tb/handle_pool_allocator_core_test.sv -----
// ============================================================================
// handle_pool_allocator_core_test
// Self-checking bench for the handle pool. Request words are driven from a
// backlog queue, a local model of the pool predicts every result word, and
// each result is compared field by field with the oldest prediction.
// ============================================================================
module handle_pool_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hpa_pkg::*;

  // The opcode left unused by the block. It must be answered with a zero
  // handle and an ok status, and it must leave the pool untouched.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Generous bound on the run. A slow but correct run is stretched by idle
  // gaps on each side and by the pipeline.
  localparam int CYCLE_LIMIT = 200000;

  // Cycles to keep watching the result channel after the last expected word,
  // so that a stray extra word from the two-stage pipeline is still caught.
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [HANDLE_W-1:0] handle;
  } request_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [1:0]          status;
  } answer_t;

  logic clk;
  logic rst;

  hpa_req_if req_ch ();
  hpa_rsp_if rsp_ch ();

  handle_pool_allocator_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // --------------------------------------------------------------------------
  // Local model of the pool. It is advanced once for every request word that
  // the block accepts, in acceptance order, so it always mirrors the block.
  // --------------------------------------------------------------------------
  logic                in_use [POOL_SIZE];
  logic [HANDLE_W-1:0] recycled [$];
  int unsigned         fresh_next;

  // Request words waiting to be driven, and result words still owed.
  request_t backlog [$];
  answer_t  owed_answers [$];

  int unsigned cycle_count;
  int unsigned errors;

  // Handshake bookkeeping, captured at the rising edge and used by the
  // drivers at the following falling edge.
  logic        req_fire;
  logic        rsp_fire;
  int unsigned req_hold;
  int unsigned rsp_hold;

  // When a side is calm it never idles, which gives stretches at full rate.
  bit req_calm;
  bit rsp_calm;

  // Applies one request to the local model and returns the result word that
  // the block must produce for it. Allocation prefers the oldest recycled
  // handle, then a never-used one, and reports exhaustion when both run out.
  function automatic answer_t serve_request(logic [1:0] op, logic [HANDLE_W-1:0] h);
    answer_t a;
    a.handle = '0;
    a.status = ST_OK;
    case (op)
      OP_ALLOC, OP_TRY_ALLOC: begin
        if (recycled.size() != 0) begin
          a.handle = recycled.pop_front();
          in_use[a.handle] = 1'b1;
        end else if (op == OP_TRY_ALLOC) begin
          a.status = ST_NO_FREED;
        end else if (fresh_next < POOL_SIZE) begin
          a.handle = fresh_next[HANDLE_W-1:0];
          in_use[a.handle] = 1'b1;
          fresh_next++;
        end else begin
          a.status = ST_EXHAUSTED;
        end
      end
      OP_FREE: begin
        // A handle never issued, or one already returned, is refused and
        // leaves the pool as it was.
        if (!in_use[h]) begin
          a.status = ST_NOT_ALLOC;
        end else begin
          in_use[h] = 1'b0;
          recycled.push_back(h);
        end
      end
      default: begin
        // The unused opcode answers with the all-zero word.
      end
    endcase
    return a;
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 5);
  endfunction

  // Picks a handle that the model currently holds as allocated, starting the
  // scan at a random point so that returns come in a scrambled order. With
  // nothing allocated it falls back to an arbitrary handle.
  function automatic logic [HANDLE_W-1:0] pick_held_handle();
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, POOL_SIZE - 1);
    for (int i = 0; i < POOL_SIZE; i++) begin
      idx = (start + i) % POOL_SIZE;
      if (in_use[idx]) return idx[HANDLE_W-1:0];
    end
    return HANDLE_W'($urandom_range(0, POOL_SIZE - 1));
  endfunction

  // Draws one request word. The weights are percentages; whatever is left
  // over goes to noise: returns of arbitrary handles and the unused opcode.
  function automatic request_t make_request(int unsigned alloc_pct, int unsigned try_pct,
                                            int unsigned free_pct);
    request_t    r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    r.handle = HANDLE_W'($urandom_range(0, 255));
    if (roll < alloc_pct) begin
      r.opcode = OP_ALLOC;
    end else if (roll < alloc_pct + try_pct) begin
      r.opcode = OP_TRY_ALLOC;
    end else if (roll < alloc_pct + try_pct + free_pct) begin
      r.opcode = OP_FREE;
      r.handle = pick_held_handle();
    end else if ($urandom_range(0, 1) == 0) begin
      r.opcode = OP_FREE;
    end else begin
      r.opcode = OP_UNUSED;
    end
    return r;
  endfunction

  // Queues one request word. The backlog is kept short so that the random
  // choices above see a model that is at most a couple of words behind.
  task automatic enqueue(logic [1:0] op, logic [HANDLE_W-1:0] h);
    request_t r;
    r.opcode = op;
    r.handle = h;
    while (backlog.size() > 1) begin
      @(posedge clk);
      #1;
    end
    backlog.push_back(r);
  endtask

  // Runs one phase of random words with the given mix. Every few dozen words
  // each side decides afresh whether it idles or runs flat out.
  task automatic run_phase(int unsigned count, int unsigned alloc_pct,
                           int unsigned try_pct, int unsigned free_pct);
    request_t r;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        req_calm = ($urandom_range(0, 3) == 0);
        rsp_calm = ($urandom_range(0, 3) == 0);
      end
      r = make_request(alloc_pct, try_pct, free_pct);
      enqueue(r.opcode, r.handle);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver. A new word is presented at the falling edge once the
  // previous one has been taken and its drawn gap has run out. The word on
  // the channel is held unchanged until the block accepts it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_hold     <= draw_gap(req_calm);
    end else if (!req_ch.valid || req_fire) begin
      if (req_hold != 0) begin
        req_ch.valid <= 1'b0;
        req_hold     <= req_hold - 1;
      end else if (backlog.size() != 0) begin
        nxt = backlog.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= nxt.opcode;
        req_ch.handle_in <= nxt.handle;
        req_hold         <= draw_gap(req_calm);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. After each accepted result word a stall is drawn, and
  // ready stays low for that many cycles before the next word may pass.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    int unsigned hold;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold     <= 0;
    end else begin
      hold = rsp_fire ? draw_gap(rsp_calm) : rsp_hold;
      if (hold != 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold     <= hold - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        rsp_hold     <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge an accepted request advances the model and
  // its prediction is queued; an accepted result is then checked against the
  // oldest prediction. Predicting first keeps the order right even if a
  // result could leave in the same cycle as its request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      req_fire <= 1'b0;
      rsp_fire <= 1'b0;
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      cycle_count++;
      req_fire <= req_ch.valid && req_ch.ready;
      rsp_fire <= rsp_ch.valid && rsp_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        owed_answers.push_back(serve_request(req_ch.opcode, req_ch.handle_in));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_answers.size() == 0) begin
          errors++;
          $error("result word with none expected: handle_out %0d, status %0d",
                 rsp_ch.handle_out, rsp_ch.status);
        end else begin
          want = owed_answers.pop_front();
          if (rsp_ch.handle_out !== want.handle) begin
            errors++;
            $error("handle_out mismatch: expected %0d, actual %0d",
                   want.handle, rsp_ch.handle_out);
          end
          if (rsp_ch.status !== want.status) begin
            errors++;
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, rsp_ch.status);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    // Every input is known from time zero, and the model starts out in the
    // reset state of the block.
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_ALLOC;
    req_ch.handle_in = '0;
    rsp_ch.ready     = 1'b0;
    req_fire         = 1'b0;
    rsp_fire         = 1'b0;
    req_hold         = 0;
    rsp_hold         = 0;
    req_calm         = 1'b0;
    rsp_calm         = 1'b0;
    cycle_count      = 0;
    errors           = 0;
    fresh_next       = 0;
    foreach (in_use[i]) in_use[i] = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. Try-allocate on an empty free list, fresh issue with
    // a handle_in that must be ignored, returns of a never-issued handle and
    // of an already returned one, the unused opcode with both extreme
    // handles, and reuse of freed handles in oldest-first order.
    enqueue(OP_TRY_ALLOC, 8'hFF);
    enqueue(OP_ALLOC,     8'hAA);
    enqueue(OP_ALLOC,     8'h55);
    enqueue(OP_FREE,      8'hFF);
    enqueue(OP_FREE,      8'h00);
    enqueue(OP_FREE,      8'h00);
    enqueue(OP_UNUSED,    8'hFF);
    enqueue(OP_UNUSED,    8'h00);
    enqueue(OP_TRY_ALLOC, 8'h00);
    enqueue(OP_FREE,      8'h01);
    enqueue(OP_FREE,      8'h00);
    enqueue(OP_ALLOC,     8'hFF);
    enqueue(OP_TRY_ALLOC, 8'hFF);
    enqueue(OP_TRY_ALLOC, 8'h00);
    enqueue(OP_FREE,      8'h02);
    enqueue(OP_FREE,      8'h01);
    enqueue(OP_FREE,      8'h00);

    // Mostly allocation, so that the fresh counter climbs toward the top of
    // the pool while a few returns keep the free list moving.
    run_phase(500, 65, 10, 15);

    // Drain the free list and use up the fresh counter, then ask twice more:
    // the pool is exhausted by then and both words must say so.
    while (recycled.size() != 0 || fresh_next < POOL_SIZE) enqueue(OP_ALLOC, 8'h00);
    enqueue(OP_ALLOC, 8'hFF);
    enqueue(OP_ALLOC, 8'h00);

    // Mostly returns, which fills the free list close to the whole pool and
    // wraps its read and write positions.
    run_phase(350, 10, 10, 70);

    // A balanced mix with plenty of noise.
    run_phase(480, 30, 15, 40);

    // Let the last request go, then wait for every owed result and watch a
    // little longer for anything extra.
    while (backlog.size() != 0 || req_ch.valid) begin
      @(posedge clk);
      #1;
    end
    while (owed_answers.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hpa_pkg.sv
sv/hpa_if.sv
sv/hpa_free_fifo.sv
sv/hpa_alloc_map.sv
sv/handle_pool_allocator_core.sv
tb/handle_pool_allocator_core_test.sv
